@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// shared constants and the quarter-wave sine table for the polar point block
// ----------------------------------------------------------------------------
package pps_pkg;

  // fraction bits of the scaled trig values, default for the top level
  localparam int TRIG_FRAC_BITS_DEF = 10;
  // fraction bits of the stored table entries (Q15)
  localparam int TABLE_FRAC_BITS    = 15;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_QUARTER = 90;

  // angle offset that makes any 16-bit signed angle positive, a multiple of 360
  localparam int ANGLE_OFFSET = 33120;

  // reciprocal of 360 for the modulo: q = (u * RECIP_360) >> RECIP_SHIFT
  localparam int RECIP_360   = 93207;
  localparam int RECIP_SHIFT = 25;

  localparam int ANGLE_W = 17;  // offset angle
  localparam int DEG_W   = 9;   // reduced angle 0..359
  localparam int IDX_W   = 7;   // table index 0..90
  localparam int ENTRY_W = 16;  // Q15 entry, up to 32768
  localparam int RAD_W   = 15;
  localparam int POLE_W  = 16;
  localparam int POINT_W = 17;

  // quarter-wave sine, Q15, indexed by whole degrees 0..90
  function automatic logic [ENTRY_W-1:0] quarter_sine(input logic [IDX_W-1:0] idx);
    logic [ENTRY_W-1:0] v;
    unique case (idx)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
      7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
      7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
      7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // fold a reduced angle 0..359 onto the quarter-wave index 0..90
  function automatic logic [IDX_W-1:0] fold_index(input logic [DEG_W-1:0] a);
    logic [DEG_W-1:0] t;
    logic [DEG_W-1:0] f;
    t = (a >= DEG_W'(DEG_HALF)) ? a - DEG_W'(DEG_HALF) : a;
    f = (t > DEG_W'(DEG_QUARTER)) ? DEG_W'(DEG_HALF) - t : t;
    return f[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/polar_point_to_screen.sv @@
// ----------------------------------------------------------------------------
// polar_point_to_screen
// turns a pole, an angle in degrees and a radius into a screen point
// ----------------------------------------------------------------------------
// Six-stage pipeline: an item is taken in every cycle in which start is high,
// and its point appears on point_x/point_y with done high for one cycle once
// it has passed the stages. busy is always low, since the pipeline never stops;
// the result must be captured in the cycle done is high. The stages, in order:
// offset and reciprocal multiply, modulo-360 subtract, table lookup, radius
// multiply, floor/ceiling shift, pole add.
// ----------------------------------------------------------------------------
module polar_point_to_screen #(
  parameter int TRIG_FRAC_BITS = pps_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pps_pkg::POLE_W-1:0]  pole_x,
  input  logic signed [pps_pkg::POLE_W-1:0]  pole_y,
  input  logic signed [pps_pkg::POLE_W-1:0]  angle_deg,
  input  logic        [pps_pkg::RAD_W-1:0]   radius,
  output logic                               done,
  output logic signed [pps_pkg::POINT_W-1:0] point_x,
  output logic signed [pps_pkg::POINT_W-1:0] point_y
);
  import pps_pkg::*;

  localparam int MAG_W   = TRIG_FRAC_BITS + 1;
  localparam int WIDE_W  = ENTRY_W + TRIG_FRAC_BITS;
  localparam int PROD_W  = MAG_W + RAD_W;
  localparam int QPROD_W = 2 * ANGLE_W;
  localparam int Q_W     = 8;
  localparam int TERM_W  = 16;

  // valid bits, one per stage
  logic [5:0] v;

  // stage 1
  logic [ANGLE_W-1:0]       u_c;
  logic [QPROD_W-1:0]       qprod_c;
  logic [ANGLE_W-1:0]       s1_u;
  logic [Q_W-1:0]           s1_q;
  logic signed [POLE_W-1:0] s1_px, s1_py;
  logic [RAD_W-1:0]         s1_r;

  // stage 2
  logic [ANGLE_W-1:0]       a_c;
  logic [DEG_W-1:0]         ac_c;
  logic [DEG_W-1:0]         s2_a, s2_ac;
  logic signed [POLE_W-1:0] s2_px, s2_py;
  logic [RAD_W-1:0]         s2_r;

  // stage 3
  logic [WIDE_W-1:0]        sin_wide_c, cos_wide_c;
  logic [MAG_W-1:0]         s3_sin_mag, s3_cos_mag;
  logic                     s3_sin_neg, s3_cos_neg;
  logic signed [POLE_W-1:0] s3_px, s3_py;
  logic [RAD_W-1:0]         s3_r;

  // stage 4
  logic [PROD_W-1:0]        s4_sin_prod, s4_cos_prod;
  logic                     s4_sin_neg, s4_cos_neg;
  logic signed [POLE_W-1:0] s4_px, s4_py;

  // stage 5
  logic [PROD_W-1:0]         sin_ceil_sum_c, cos_ceil_sum_c;
  logic [TERM_W-1:0]         sin_fl_c, sin_ce_c, cos_fl_c, cos_ce_c;
  logic signed [POINT_W-1:0] s5_term_x, s5_term_y;
  logic signed [POLE_W-1:0]  s5_px, s5_py;

  assign busy = 1'b0;
  assign done = v[5];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], start};
    end
  end

  // stage 1: offset angle positive, estimate quotient by 360
  assign u_c     = ANGLE_W'({angle_deg[POLE_W-1], angle_deg}) + ANGLE_W'(ANGLE_OFFSET);
  assign qprod_c = QPROD_W'(u_c) * QPROD_W'(RECIP_360);

  always_ff @(posedge clk) begin
    s1_u  <= u_c;
    s1_q  <= qprod_c[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    s1_px <= pole_x;
    s1_py <= pole_y;
    s1_r  <= radius;
  end

  // stage 2: remainder gives angle in 0..359, cosine angle is 90 ahead
  assign a_c  = s1_u - ANGLE_W'(s1_q) * ANGLE_W'(DEG_FULL);
  assign ac_c = (a_c[DEG_W-1:0] >= DEG_W'(DEG_FULL - DEG_QUARTER))
              ? a_c[DEG_W-1:0] - DEG_W'(DEG_FULL - DEG_QUARTER)
              : a_c[DEG_W-1:0] + DEG_W'(DEG_QUARTER);

  always_ff @(posedge clk) begin
    s2_a  <= a_c[DEG_W-1:0];
    s2_ac <= ac_c;
    s2_px <= s1_px;
    s2_py <= s1_py;
    s2_r  <= s1_r;
  end

  // stage 3: fold, table lookup and scaling to TRIG_FRAC_BITS
  assign sin_wide_c = {quarter_sine(fold_index(s2_a)), TRIG_FRAC_BITS'(0)};
  assign cos_wide_c = {quarter_sine(fold_index(s2_ac)), TRIG_FRAC_BITS'(0)};

  always_ff @(posedge clk) begin
    s3_sin_mag <= sin_wide_c[WIDE_W-1:TABLE_FRAC_BITS];
    s3_cos_mag <= cos_wide_c[WIDE_W-1:TABLE_FRAC_BITS];
    s3_sin_neg <= (s2_a > DEG_W'(DEG_HALF));
    s3_cos_neg <= (s2_ac > DEG_W'(DEG_HALF));
    s3_px      <= s2_px;
    s3_py      <= s2_py;
    s3_r       <= s2_r;
  end

  // stage 4: magnitude times radius
  always_ff @(posedge clk) begin
    s4_sin_prod <= PROD_W'(s3_sin_mag) * PROD_W'(s3_r);
    s4_cos_prod <= PROD_W'(s3_cos_mag) * PROD_W'(s3_r);
    s4_sin_neg  <= s3_sin_neg;
    s4_cos_neg  <= s3_cos_neg;
    s4_px       <= s3_px;
    s4_py       <= s3_py;
  end

  // stage 5: floor shift, negative products round away from zero in magnitude
  assign sin_ceil_sum_c = s4_sin_prod + PROD_W'((1 << TRIG_FRAC_BITS) - 1);
  assign cos_ceil_sum_c = s4_cos_prod + PROD_W'((1 << TRIG_FRAC_BITS) - 1);
  assign sin_fl_c = s4_sin_prod[PROD_W-1:TRIG_FRAC_BITS];
  assign cos_fl_c = s4_cos_prod[PROD_W-1:TRIG_FRAC_BITS];
  assign sin_ce_c = sin_ceil_sum_c[PROD_W-1:TRIG_FRAC_BITS];
  assign cos_ce_c = cos_ceil_sum_c[PROD_W-1:TRIG_FRAC_BITS];

  always_ff @(posedge clk) begin
    s5_term_x <= s4_cos_neg ? POINT_W'(0) - POINT_W'(cos_ce_c) : POINT_W'(cos_fl_c);
    // screen y grows downward, so the sine term is subtracted
    s5_term_y <= s4_sin_neg ? POINT_W'(sin_ce_c) : POINT_W'(0) - POINT_W'(sin_fl_c);
    s5_px     <= s4_px;
    s5_py     <= s4_py;
  end

  // stage 6: add the pole
  always_ff @(posedge clk) begin
    point_x <= POINT_W'(s5_px) + s5_term_x;
    point_y <= POINT_W'(s5_py) + s5_term_y;
  end

  // every item that is taken comes out with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done) else $error("item lost in pipeline");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##6 !done) else $error("result without item");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> (s2_a < DEG_W'(DEG_FULL)) && (s2_ac < DEG_W'(DEG_FULL)))
    else $error("angle reduction out of range");

  a_index: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> (fold_index(s2_a) <= IDX_W'(DEG_QUARTER))
          && (fold_index(s2_ac) <= IDX_W'(DEG_QUARTER)))
    else $error("table index out of range");

endmodule
